// File: design/scrm_pkg.sv
// Shared types, widths, register indexes and constants of the run centroid mapper.
package scrm_pkg;

    localparam int COORD_W    = 13;
    localparam int BORDER_W   = 10;
    localparam int SCREEN_W   = 12;
    localparam int TOUCH_W    = 12;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic        [COORD_W-1:0]  depth_t;
    typedef logic        [BORDER_W-1:0] border_t;
    typedef logic        [SCREEN_W-1:0] screen_t;
    typedef logic signed [TOUCH_W-1:0]  touch_t;

    typedef struct packed {
        coord_t  ref_a_x;
        coord_t  ref_b_x;
        depth_t  ref_a_depth;
        depth_t  ref_b_depth;
        border_t border_offset;
        screen_t screen_width;
        screen_t screen_height;
    } scrm_cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_A_X       = 3'd0,
        CFG_REF_B_X       = 3'd1,
        CFG_REF_A_DEPTH   = 3'd2,
        CFG_REF_B_DEPTH   = 3'd3,
        CFG_BORDER_OFFSET = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6
    } cfg_idx_t;

    localparam coord_t  RST_REF_A_X       = -13'sd300;
    localparam coord_t  RST_REF_B_X       = 13'sd300;
    localparam depth_t  RST_REF_A_DEPTH   = 13'd300;
    localparam depth_t  RST_REF_B_DEPTH   = 13'd1400;
    localparam border_t RST_BORDER_OFFSET = 10'd100;
    localparam screen_t RST_SCREEN_WIDTH  = 12'd800;
    localparam screen_t RST_SCREEN_HEIGHT = 12'd600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ND,
        ST_NR,
        ST_INNER,
        ST_NUM,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } scrm_state_t;

endpackage

// File: design/scrm_if.sv
// Handshake channels: scanline points in, touch positions out.
interface scrm_point_if;
    import scrm_pkg::*;

    logic   valid;
    logic   ready;
    coord_t world_x;
    depth_t world_depth;
    logic   row_last;

    modport source (output valid, output world_x, output world_depth, output row_last,
                    input ready);
    modport sink   (input valid, input world_x, input world_depth, input row_last,
                    output ready);
endinterface

interface scrm_touch_if;
    import scrm_pkg::*;

    logic   valid;
    logic   ready;
    touch_t touch_x;
    touch_t touch_y;

    modport source (output valid, output touch_x, output touch_y, input ready);
    modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

// File: design/scanline_run_centroid_mapper.sv
// Top level: config registers, front end, job queue and mapping back end.
//
//  channel   dir  handshake          word
//  points    in   valid/ready        world_x, world_depth, row_last
//  touches   out  valid/ready        touch_x, touch_y
//  cfg       in   cfg_we             cfg_index, cfg_data
//
// A point is taken every cycle while the 4-entry job queue has room.
// Each closed run passes through the bit-serial divider, shared by both axes, once per axis;
// an axis whose references coincide skips the divide.
// Reset clears run state, queue and output, and loads the default calibration.
// A full queue stalls points; a stalled touches channel holds the back end.
module scanline_run_centroid_mapper #(
    parameter int ROW_POINTS = 640
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [scrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scrm_pkg::CFG_DATA_W-1:0]      cfg_data,
    scrm_point_if.sink                           points,
    scrm_touch_if.source                         touches
);
    import scrm_pkg::*;

    localparam int CNT_W     = $clog2(ROW_POINTS);
    localparam int SUM_W     = CNT_W + COORD_W;
    localparam int JOB_W     = 2 * SUM_W + CNT_W;
    localparam int Q_DEPTH   = 4;

    scrm_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_a_x       <= RST_REF_A_X;
            cfg_reg.ref_b_x       <= RST_REF_B_X;
            cfg_reg.ref_a_depth   <= RST_REF_A_DEPTH;
            cfg_reg.ref_b_depth   <= RST_REF_B_DEPTH;
            cfg_reg.border_offset <= RST_BORDER_OFFSET;
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REF_A_X:       cfg_reg.ref_a_x       <= $signed(cfg_data[COORD_W-1:0]);
                CFG_REF_B_X:       cfg_reg.ref_b_x       <= $signed(cfg_data[COORD_W-1:0]);
                CFG_REF_A_DEPTH:   cfg_reg.ref_a_depth   <= cfg_data[COORD_W-1:0];
                CFG_REF_B_DEPTH:   cfg_reg.ref_b_depth   <= cfg_data[COORD_W-1:0];
                CFG_BORDER_OFFSET: cfg_reg.border_offset <= cfg_data[BORDER_W-1:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic                    push_valid, push_ready, pop_valid, pop;
    logic signed [SUM_W-1:0] f_lat, b_lat;
    logic        [SUM_W-1:0] f_dep, b_dep;
    logic        [CNT_W-1:0] f_cnt, b_cnt;
    logic        [JOB_W-1:0] q_din, q_dout;

    scrm_front #(
        .ROW_POINTS (ROW_POINTS),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .points    (points),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_lat   (f_lat),
        .job_dep   (f_dep),
        .job_cnt   (f_cnt)
    );

    assign q_din = {f_lat, f_dep, f_cnt};

    scrm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .din        (q_din),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .dout       (q_dout)
    );

    assign b_lat = $signed(q_dout[JOB_W-1 -: SUM_W]);
    assign b_dep = q_dout[CNT_W +: SUM_W];
    assign b_cnt = q_dout[CNT_W-1:0];

    scrm_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job_pop   (pop),
        .job_lat   (b_lat),
        .job_dep   (b_dep),
        .job_cnt   (b_cnt),
        .touches   (touches)
    );

endmodule

// File: design/scrm_front.sv
// Front end: window test and run accumulation; finished runs go out as jobs.
module scrm_front #(
    parameter int ROW_POINTS = 640,
    parameter int CNT_W      = 10,
    parameter int SUM_W      = 23
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scrm_pkg::scrm_cfg_t    cfg,
    scrm_point_if.sink             points,
    output logic                   job_valid,
    input  logic                   job_ready,
    output logic signed [SUM_W-1:0] job_lat,
    output logic        [SUM_W-1:0] job_dep,
    output logic        [CNT_W-1:0] job_cnt
);
    import scrm_pkg::*;

    localparam int WIN_W = COORD_W + 2;

    logic                    run_active_reg, run_active_next;
    logic signed [SUM_W-1:0] sum_lat_reg, sum_lat_next;
    logic        [SUM_W-1:0] sum_dep_reg, sum_dep_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [WIN_W-1:0] x_w, lo_x, hi_x, z_w, lo_z, hi_z, two_b, one_b;
    logic hit, emit, acc;

    always_comb
    begin
        two_b = $signed({{(WIN_W-BORDER_W-1){1'b0}}, cfg.border_offset, 1'b0});
        one_b = $signed({{(WIN_W-BORDER_W){1'b0}}, cfg.border_offset});
        x_w   = $signed({{2{points.world_x[COORD_W-1]}}, points.world_x});
        lo_x  = $signed({{2{cfg.ref_b_x[COORD_W-1]}}, cfg.ref_b_x}) - two_b;
        hi_x  = $signed({{2{cfg.ref_a_x[COORD_W-1]}}, cfg.ref_a_x}) + two_b;
        z_w   = $signed({2'b00, points.world_depth});
        lo_z  = $signed({2'b00, cfg.ref_a_depth}) - one_b;
        hi_z  = $signed({2'b00, cfg.ref_b_depth}) + one_b;
        hit   = (x_w > lo_x) && (x_w < hi_x) && (z_w > lo_z) && (z_w < hi_z);
    end

    assign emit         = !hit && run_active_reg && (cnt_reg != '0);
    assign points.ready = job_ready;
    assign acc          = points.valid && job_ready;
    assign job_valid    = points.valid && emit;
    assign job_lat      = sum_lat_reg;
    assign job_dep      = sum_dep_reg;
    assign job_cnt      = cnt_reg;

    always_comb
    begin
        run_active_next = run_active_reg;
        sum_lat_next    = sum_lat_reg;
        sum_dep_next    = sum_dep_reg;
        cnt_next        = cnt_reg;
        if (acc)
        begin
            if (hit)
            begin
                run_active_next = 1'b1;
                // run length saturates; later hits keep the run open unsummed
                if (cnt_reg < CNT_W'(ROW_POINTS - 1))
                begin
                    sum_lat_next = sum_lat_reg
                                 + $signed({{(SUM_W-COORD_W){points.world_x[COORD_W-1]}},
                                            points.world_x});
                    sum_dep_next = sum_dep_reg + {{(SUM_W-COORD_W){1'b0}}, points.world_depth};
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            else
            begin
                run_active_next = 1'b0;
                sum_lat_next    = '0;
                sum_dep_next    = '0;
                cnt_next        = '0;
            end
            if (points.row_last)
            begin
                run_active_next = 1'b0;
                sum_lat_next    = '0;
                sum_dep_next    = '0;
                cnt_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            sum_lat_reg    <= '0;
            sum_dep_reg    <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            sum_lat_reg    <= sum_lat_next;
            sum_dep_reg    <= sum_dep_next;
            cnt_reg        <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROW_POINTS - 1))
        else $error("run count above cap");
    a_cnt_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> run_active_reg)
        else $error("summed run without active flag");
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && points.ready && points.row_last) |=>
        (cnt_reg == '0 && !run_active_reg && sum_lat_reg == '0 && sum_dep_reg == '0))
        else $error("run survived end of row");
`endif

endmodule

// File: design/scrm_fifo.sv
// Small register queue between front and back end.
module scrm_fifo #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] din,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] dout
);
    import scrm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign dout       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: design/scrm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module scrm_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import scrm_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [DEN_W:0]    rem_sh, rem_sub;
    logic              ge;

    // quo_reg shifts numerator bits out the top and quotient bits in at the bottom
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: design/scrm_back.sv
// Back end: maps a run's sums to screen pixels, one axis after the other.
module scrm_back #(
    parameter int CNT_W = 10,
    parameter int SUM_W = 23
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scrm_pkg::scrm_cfg_t     cfg,
    input  logic                    job_valid,
    output logic                    job_pop,
    input  logic signed [SUM_W-1:0] job_lat,
    input  logic        [SUM_W-1:0] job_dep,
    input  logic        [CNT_W-1:0] job_cnt,
    scrm_touch_if.source            touches
);
    import scrm_pkg::*;

    localparam int INN_W   = CNT_W + 17;
    localparam int MUL_W   = INN_W + DIFF_W;
    localparam int MAG_W   = CNT_W + 29;
    localparam int DMAG_W  = CNT_W + 14;
    localparam int S_W     = SCREEN_W + 1;

    scrm_state_t state_reg, state_next;
    logic        axis_reg;   // 0: touch_x from depth, 1: touch_y from lateral

    logic signed [SUM_W-1:0] lat_reg;
    logic        [SUM_W-1:0] dep_reg;
    logic        [CNT_W-1:0] cnt_reg;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [INN_W-1:0] nd_reg, inner_reg, den_reg;
    logic                    neg_reg;
    touch_t                  tx_reg, ty_reg;
    logic                    out_valid_reg;
    touch_t                  out_x_reg, out_y_reg;

    logic signed [SUM_W:0]    sum_sel;
    logic signed [INN_W-1:0]  sum_ext, nr;
    logic signed [DIFF_W-1:0] ref_lo, ref_hi, d_ax;
    logic                     d_zero;
    screen_t                  size_sel;
    logic signed [S_W-1:0]    s_ax;
    touch_t                   half_neg, res_div, res_val;
    logic signed [INN_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [MUL_W-1:0]  mul_p, prod_abs;
    logic signed [INN_W-1:0]  den_abs;

    logic div_start, div_busy, div_done, store_res, out_load;
    logic [MAG_W-1:0] div_quot;

    // axis operands
    always_comb
    begin
        if (axis_reg)
        begin
            sum_sel  = $signed({lat_reg[SUM_W-1], lat_reg});
            ref_lo   = $signed({cfg.ref_a_x[COORD_W-1], cfg.ref_a_x});
            ref_hi   = $signed({cfg.ref_b_x[COORD_W-1], cfg.ref_b_x});
            size_sel = cfg.screen_height;
        end
        else
        begin
            sum_sel  = $signed({1'b0, dep_reg});
            ref_lo   = $signed({1'b0, cfg.ref_a_depth});
            ref_hi   = $signed({1'b0, cfg.ref_b_depth});
            size_sel = cfg.screen_width;
        end
        d_ax     = ref_hi - ref_lo;
        d_zero   = (d_ax == '0);
        s_ax     = $signed({1'b0, size_sel}) - $signed({2'b00, cfg.border_offset, 1'b0});
        half_neg = -$signed({1'b0, size_sel[SCREEN_W-1:1]});
        sum_ext  = $signed({{(INN_W-SUM_W-1){sum_sel[SUM_W]}}, sum_sel});
        nr       = $signed(prod_reg[INN_W-1:0]);
    end

    // one shared multiplier
    always_comb
    begin
        mul_a = $signed({{(INN_W-CNT_W){1'b0}}, cnt_reg});
        mul_b = d_ax;
        unique case (state_reg)
            ST_NR:   mul_b = ref_lo;
            ST_NUM:
            begin
                mul_a = inner_reg;
                mul_b = $signed({{(DIFF_W-S_W){s_ax[S_W-1]}}, s_ax});
            end
            ST_IDLE, ST_ND, ST_INNER, ST_DIV_GO, ST_DIV, ST_OUT: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    assign prod_abs = prod_reg[MUL_W-1] ? -prod_reg : prod_reg;
    assign den_abs  = den_reg[INN_W-1] ? -den_reg : den_reg;

    scrm_div #(
        .NUM_W (MAG_W),
        .DEN_W (DMAG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_abs[MAG_W-1:0]),
        .den   (den_abs[DMAG_W-1:0]),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // truncated quotient, signed and clamped to the touch_t range; minus half the screen size if references coincide
    always_comb
    begin
        if (neg_reg)
            res_div = (div_quot > MAG_W'(2048)) ? touch_t'(-2048)
                                                : -$signed(div_quot[TOUCH_W-1:0]);
        else
            res_div = (div_quot > MAG_W'(2047)) ? touch_t'(2047)
                                                : $signed(div_quot[TOUCH_W-1:0]);
        res_val = (state_reg == ST_ND) ? half_neg : res_div;
    end

    // control outputs
    always_comb
    begin
        job_pop   = 1'b0;
        div_start = 1'b0;
        store_res = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   job_pop   = job_valid;
            ST_ND:     store_res = d_zero;
            ST_DIV_GO: div_start = 1'b1;
            ST_DIV:    store_res = div_done;
            ST_OUT:    out_load  = !out_valid_reg || touches.ready;
            ST_NR, ST_INNER, ST_NUM: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (job_valid) state_next = ST_ND;
            ST_ND:
            begin
                if (!d_zero)
                    state_next = ST_NR;
                else
                    state_next = axis_reg ? ST_OUT : ST_ND;
            end
            ST_NR:     state_next = ST_INNER;
            ST_INNER:  state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = axis_reg ? ST_OUT : ST_ND;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
                axis_reg <= 1'b0;
            else if (store_res)
                axis_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (touches.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            lat_reg <= job_lat;
            dep_reg <= job_dep;
            cnt_reg <= job_cnt;
        end
        if (state_reg == ST_ND || state_reg == ST_NR || state_reg == ST_NUM)
            prod_reg <= mul_p;
        if (state_reg == ST_NR)
            nd_reg <= nr;
        if (state_reg == ST_INNER)
            inner_reg <= nd_reg - ((sum_ext - nr) <<< 1);
        if (state_reg == ST_NUM)
            den_reg <= nd_reg <<< 1;
        if (div_start)
            neg_reg <= prod_reg[MUL_W-1] ^ den_reg[INN_W-1];
        if (store_res)
        begin
            if (axis_reg)
                ty_reg <= res_val;
            else
                tx_reg <= res_val;
        end
        if (out_load)
        begin
            out_x_reg <= tx_reg;
            out_y_reg <= axis_reg ? ty_reg : ty_reg;
        end
    end

    assign touches.valid   = out_valid_reg;
    assign touches.touch_x = out_x_reg;
    assign touches.touch_y = out_y_reg;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("quotient arrived outside divide state");
    a_both_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> axis_reg)
        else $error("output before second axis");
`endif

endmodule
